/* rtl/core/rrda_pkg.sv */
// shared constants, request and register codes, config struct and address helper
// for the rain declutter accumulator; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rrda_pkg;

  // grid geometry
  localparam int GRID_SIZE = 400;
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;
  localparam int AW        = $clog2(CELLS);
  localparam int KW        = AW + 1;
  localparam int CW        = $clog2(GRID_SIZE);

  // request codes
  localparam logic [2:0] REQ_WRITE     = 3'd0;
  localparam logic [2:0] REQ_MAP_DONE  = 3'd1;
  localparam logic [2:0] REQ_HOUR_DONE = 3'd2;
  localparam logic [2:0] REQ_READ      = 3'd3;
  localparam logic [2:0] REQ_CLEAR     = 3'd4;

  // register indexes
  localparam logic [3:0] CFG_THRESHOLD   = 4'd0;
  localparam logic [3:0] CFG_NEIGHBOR    = 4'd1;
  localparam logic [3:0] CFG_MAP_PASSES  = 4'd2;
  localparam logic [3:0] CFG_HOUR_PASSES = 4'd3;

  // divide by twelve: (x >> 2) * ceil(2^25 / 3) >> 25
  localparam logic [23:0] DIV3_MULT  = 24'd11184811;
  localparam int          DIV3_SHIFT = 25;

  localparam logic [23:0] SUM_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [15:0] thr;
    logic [3:0]  nmin;
    logic [4:0]  map_passes;
    logic [4:0]  hour_passes;
  } cfg_t;

  // linear address of a grid cell
  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    logic [AW-1:0] base;
    base = AW'(r) * AW'(GRID_SIZE);
    return base + AW'(c);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/radar_rain_declutter_accumulator.sv */
// top level: configuration registers, map and hourly sum memories, divider
// depends on rrda_pkg, rrda_ram, rrda_div12, rrda_seq
`timescale 1ns / 1ps
`default_nettype none

// Usage: a request is a transaction taken when start is high and busy is low.
// req_type selects pixel write, map complete, hour complete, read total or
// clear total; row/col address the cell, pixel_value carries write data.
// Pixel writes keep busy low, so one may follow per cycle.
// A read total returns hour_total with a one-cycle strobe hour_total_valid
// through three registers after acceptance (ram read, divide multiply, output register);
// the receiver cannot stall, so the result is shown exactly once.
// Map complete runs 4*GRID_SIZE border writes, then per pass and per interior
// cell reads the center (S_CTR, S_CHK) and, unless it is zero, the nine window cells
// (S_WIN, S_WLAST) and decides (S_DEC), then accumulates the map and clears it.
// Hour complete runs the border and passes on the sum memory only.
// Clear total sweeps the whole sum memory.
// After reset both memories are cleared with busy high; configuration writes
// (cfg_we, cfg_index, cfg_data) are taken at any time and belong only to idle
// periods.
module radar_rain_declutter_accumulator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  req_type,
  input  wire logic [8:0]  row,
  input  wire logic [8:0]  col,
  input  wire logic [15:0] pixel_value,
  output logic [20:0]      hour_total,
  output logic             hour_total_valid
);
  import rrda_pkg::*;

  cfg_t          cfg;
  logic [AW-1:0] waddr, raddr;
  logic          m_we, h_we;
  logic [15:0]   m_wdata, m_rdata;
  logic [23:0]   h_wdata, h_rdata;
  logic [20:0]   quot;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr         <= 16'd25;
      cfg.nmin        <= 4'd5;
      cfg.map_passes  <= 5'd16;
      cfg.hour_passes <= 5'd15;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD:   cfg.thr         <= cfg_data;
        CFG_NEIGHBOR:    cfg.nmin        <= cfg_data[3:0];
        CFG_MAP_PASSES:  cfg.map_passes  <= cfg_data[4:0];
        CFG_HOUR_PASSES: cfg.hour_passes <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // five-minute map
  rrda_ram #(.W(16), .D(CELLS), .AWP(AW)) u_map_ram (
    .clk(clk), .we(m_we), .waddr(waddr), .wdata(m_wdata),
    .raddr(raddr), .rdata(m_rdata)
  );

  // hourly sum
  rrda_ram #(.W(24), .D(CELLS), .AWP(AW)) u_sum_ram (
    .clk(clk), .we(h_we), .waddr(waddr), .wdata(h_wdata),
    .raddr(raddr), .rdata(h_rdata)
  );

  // read path divider
  rrda_div12 u_div12 (
    .clk(clk), .x(h_rdata), .q(quot)
  );

  // sequencer
  rrda_seq u_seq (
    .clk(clk), .rst(rst), .cfg(cfg),
    .start(start), .req_type(req_type), .row(row), .col(col),
    .pixel_value(pixel_value), .busy(busy),
    .waddr(waddr), .raddr(raddr),
    .m_we(m_we), .m_wdata(m_wdata), .m_rdata(m_rdata),
    .h_we(h_we), .h_wdata(h_wdata), .h_rdata(h_rdata),
    .quot(quot), .hour_total(hour_total), .hour_total_valid(hour_total_valid)
  );

endmodule

`default_nettype wire

/* rtl/core/rrda_ram.sv */
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rrda_ram #(
  parameter int W   = 16,
  parameter int D   = 1024,
  parameter int AWP = $clog2(D)
) (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire logic [AWP-1:0] waddr,
  input  wire logic [W-1:0]   wdata,
  input  wire logic [AWP-1:0] raddr,
  output logic      [W-1:0]   rdata
);

  logic [W-1:0] mem [D];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/rrda_div12.sv */
// accumulator cell divided by twelve, one multiply stage
// depends on rrda_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrda_div12 (
  input  wire logic        clk,
  input  wire logic [23:0] x,
  output logic      [20:0] q
);
  import rrda_pkg::*;

  logic [45:0] prod;

  // quarter, then reciprocal of three
  always_ff @(posedge clk) begin
    prod <= 46'(x[23:2]) * 46'(DIV3_MULT);
  end

  assign q = prod[DIV3_SHIFT+20:DIV3_SHIFT];

endmodule

`default_nettype wire

/* rtl/core/rrda_seq.sv */
// sequencer: request decode, clearing sweeps, border zeroing, despeckle passes,
// accumulation and reads; depends on rrda_pkg, drives both rams
`timescale 1ns / 1ps
`default_nettype none

module rrda_seq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rrda_pkg::cfg_t       cfg,
  input  wire logic                 start,
  input  wire logic [2:0]           req_type,
  input  wire logic [8:0]           row,
  input  wire logic [8:0]           col,
  input  wire logic [15:0]          pixel_value,
  output logic                      busy,
  output logic [rrda_pkg::AW-1:0]   waddr,
  output logic [rrda_pkg::AW-1:0]   raddr,
  output logic                      m_we,
  output logic [15:0]               m_wdata,
  input  wire logic [15:0]          m_rdata,
  output logic                      h_we,
  output logic [23:0]               h_wdata,
  input  wire logic [23:0]          h_rdata,
  input  wire logic [20:0]          quot,
  output logic [20:0]               hour_total,
  output logic                      hour_total_valid
);
  import rrda_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD1, S_RD2, S_HCLR, S_BORD,
    S_CTR, S_CHK, S_WIN, S_WLAST, S_DEC, S_ACC
  } state_t;

  state_t        state;
  logic          mode_hour;
  logic [KW-1:0] k;
  logic [1:0]    sub;
  logic [4:0]    pass;
  logic [CW-1:0] oa, ob;
  logic [1:0]    wr, wc;
  logic [3:0]    wet;
  logic          pend;
  logic          acc_wv;
  logic [AW-1:0] acc_wa;
  logic          rd_inside;

  logic          in_inside;
  logic [AW-1:0] in_addr;
  logic [CW-1:0] cr, cc, kc;
  logic [AW-1:0] ctr_addr, win_addr, bord_addr;
  logic [23:0]   limit;
  logic          hit, center_zero;
  logic [4:0]    npass;
  logic          last_inner, last_outer, last_pass;
  logic [24:0]   acc_sum;
  logic [23:0]   sat;
  logic [3:0]    wet_next;

  // input address
  assign in_inside = (int'(row) < GRID_SIZE) && (int'(col) < GRID_SIZE);
  assign in_addr   = cell_addr(CW'(row), CW'(col));

  // current cell: hour passes go by rows, map passes by columns
  assign cr       = mode_hour ? oa : ob;
  assign cc       = mode_hour ? ob : oa;
  assign ctr_addr = cell_addr(cr, cc);
  assign win_addr = cell_addr(cr + CW'(wr) - CW'(1), cc + CW'(wc) - CW'(1));

  // border cell of this sweep step
  assign kc = CW'(k);
  always_comb begin
    case (sub)
      2'd0:    bord_addr = cell_addr(kc, CW'(0));
      2'd1:    bord_addr = cell_addr(kc, CW'(GRID_SIZE - 1));
      2'd2:    bord_addr = cell_addr(CW'(0), kc);
      default: bord_addr = cell_addr(CW'(GRID_SIZE - 1), kc);
    endcase
  end

  // wet test against the threshold, scaled by twelve for the hourly sum
  assign limit       = 24'(cfg.thr) * 24'd12;
  assign hit         = mode_hour ? (h_rdata > limit) : (m_rdata > cfg.thr);
  assign center_zero = mode_hour ? (h_rdata == 24'd0) : (m_rdata == 16'd0);
  assign wet_next    = wet + 4'(hit);

  assign npass      = mode_hour ? cfg.hour_passes : cfg.map_passes;
  assign last_inner = (ob == CW'(GRID_SIZE - 2));
  assign last_outer = (oa == CW'(GRID_SIZE - 2));
  assign last_pass  = (6'(pass) + 6'd1 == 6'(npass));

  // saturating accumulate
  assign acc_sum = 25'(h_rdata) + 25'(m_rdata);
  assign sat     = acc_sum[24] ? SUM_MAX : acc_sum[23:0];

  assign busy = (state != S_IDLE);

  // memory port drive
  always_comb begin
    m_we    = 1'b0;
    h_we    = 1'b0;
    m_wdata = 16'd0;
    h_wdata = 24'd0;
    waddr   = in_addr;
    raddr   = in_addr;
    case (state)
      S_CLR: begin
        waddr = k[AW-1:0];
        m_we  = 1'b1;
        h_we  = 1'b1;
      end
      S_HCLR: begin
        waddr = k[AW-1:0];
        h_we  = 1'b1;
      end
      S_IDLE: begin
        m_we    = start && (req_type == REQ_WRITE) && in_inside;
        m_wdata = pixel_value;
      end
      S_BORD: begin
        waddr = bord_addr;
        m_we  = !mode_hour;
        h_we  = mode_hour;
      end
      S_CTR: begin
        raddr = ctr_addr;
      end
      S_WIN: begin
        raddr = win_addr;
      end
      S_DEC: begin
        waddr = ctr_addr;
        if (wet < cfg.nmin) begin
          m_we = !mode_hour;
          h_we = mode_hour;
        end
      end
      S_ACC: begin
        raddr   = k[AW-1:0];
        waddr   = acc_wa;
        m_we    = acc_wv;
        h_we    = acc_wv;
        h_wdata = sat;
      end
      default: begin
      end
    endcase
  end

  // control state and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLR;
      k                <= '0;
      pend             <= 1'b0;
      acc_wv           <= 1'b0;
      hour_total_valid <= 1'b0;
      mode_hour        <= 1'b0;
    end else begin
      hour_total_valid <= 1'b0;
      case (state)
        S_CLR, S_HCLR: begin
          k <= k + KW'(1);
          if (k == KW'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            case (req_type)
              REQ_MAP_DONE: begin
                mode_hour <= 1'b0;
                k         <= '0;
                sub       <= 2'd0;
                state     <= S_BORD;
              end
              REQ_HOUR_DONE: begin
                mode_hour <= 1'b1;
                k         <= '0;
                sub       <= 2'd0;
                state     <= S_BORD;
              end
              REQ_READ: begin
                rd_inside <= in_inside;
                state     <= S_RD1;
              end
              REQ_CLEAR: begin
                k     <= '0;
                state <= S_HCLR;
              end
              default: begin
              end
            endcase
          end
        end
        S_RD1: begin
          state <= S_RD2;
        end
        S_RD2: begin
          hour_total       <= rd_inside ? quot : 21'd0;
          hour_total_valid <= 1'b1;
          state            <= S_IDLE;
        end
        S_BORD: begin
          sub <= sub + 2'd1;
          if (sub == 2'd3) begin
            k <= k + KW'(1);
            if (k == KW'(GRID_SIZE - 1)) begin
              if (npass == 5'd0) begin
                k     <= '0;
                state <= mode_hour ? S_IDLE : S_ACC;
              end else begin
                oa    <= CW'(1);
                ob    <= CW'(1);
                pass  <= 5'd0;
                state <= S_CTR;
              end
            end
          end
        end
        S_CTR: begin
          state <= S_CHK;
        end
        S_WIN: begin
          pend <= 1'b1;
          if (pend) begin
            wet <= wet_next;
          end
          wc <= (wc == 2'd2) ? 2'd0 : wc + 2'd1;
          if (wc == 2'd2) begin
            wr <= wr + 2'd1;
            if (wr == 2'd2) begin
              state <= S_WLAST;
            end
          end
        end
        S_WLAST: begin
          wet   <= wet_next;
          pend  <= 1'b0;
          state <= S_DEC;
        end
        S_CHK, S_DEC: begin
          if (state == S_CHK && !center_zero) begin
            wr    <= 2'd0;
            wc    <= 2'd0;
            wet   <= 4'd0;
            state <= S_WIN;
          end else begin
            // next cell of the scan
            state <= S_CTR;
            if (last_inner) begin
              ob <= CW'(1);
              if (last_outer) begin
                oa   <= CW'(1);
                pass <= pass + 5'd1;
                if (last_pass) begin
                  k     <= '0;
                  state <= mode_hour ? S_IDLE : S_ACC;
                end
              end else begin
                oa <= oa + CW'(1);
              end
            end else begin
              ob <= ob + CW'(1);
            end
          end
        end
        S_ACC: begin
          if (k != KW'(CELLS)) begin
            acc_wv <= 1'b1;
            acc_wa <= k[AW-1:0];
            k      <= k + KW'(1);
          end else begin
            acc_wv <= 1'b0;
            if (acc_wv) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // result only follows the divide stage
  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    hour_total_valid |-> $past(state == S_RD2))
    else $error("result strobe without read");

  // decision only after the last window sample
  a_dec_src: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEC) |-> $past(state == S_WLAST))
    else $error("despeckle decision without full window");

  // a window holds at most nine cells
  a_wet_max: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEC) |-> (wet <= 4'd9))
    else $error("wet count overflow");

  // the clearing sweep runs after reset
  a_rst_busy: assert property (@(posedge clk)
    $past(rst) |-> busy)
    else $error("idle right after reset");
`endif

endmodule

`default_nettype wire

/* verif/radar_rain_declutter_accumulator_tb.sv */
// testbench for the rain declutter accumulator: pixel loads, despeckle on map and
// hour complete, reads and clears, checked against an in-bench model; uses rrda_pkg
`timescale 1ns / 1ps
`default_nettype none

module radar_rain_declutter_accumulator_tb;
  import rrda_pkg::*;

  // request codes the block ignores
  localparam logic [2:0] REQ_SPARE_LO  = 3'd5;
  localparam logic [2:0] REQ_SPARE_MID = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI  = 3'd7;
  // register indexes that hold nothing
  localparam logic [3:0] CFG_SPARE     = 4'd7;
  localparam logic [3:0] CFG_SPARE_TOP = 4'd15;
  localparam int         DRAIN_CYCLES  = 8;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [3:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        start;
  logic        busy;
  logic [2:0]  req_type;
  logic [8:0]  row;
  logic [8:0]  col;
  logic [15:0] pixel_value;
  logic [20:0] hour_total;
  logic        hour_total_valid;

  radar_rain_declutter_accumulator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy), .req_type(req_type), .row(row), .col(col),
    .pixel_value(pixel_value), .hour_total(hour_total), .hour_total_valid(hour_total_valid)
  );

  // model state
  logic [15:0] rain_map  [CELLS];
  logic [23:0] hour_sums [CELLS];
  int unsigned thr_cfg, nmin_cfg, map_passes_cfg, hour_passes_cfg;
  logic [20:0] totals_due [$];

  int errors, n_sent, n_reads_checked, n_map_done, n_hour_done;
  int burst_left;
  bit pace_on;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #1_000_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic report(input string what, input logic [20:0] exp_v, input logic [20:0] got_v);
    if (errors < 20) begin
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
    end
    errors++;
  endtask

  // result check, one read total per strobe
  always @(posedge clk) begin
    if (!rst && hour_total_valid) begin
      if (totals_due.size() == 0) begin
        report("unexpected hour_total", 21'd0, hour_total);
      end else begin
        if (hour_total !== totals_due[0]) begin
          report("hour_total", totals_due[0], hour_total);
        end
        void'(totals_due.pop_front());
        n_reads_checked++;
      end
    end
  end

  // map complete: border, column-order passes, accumulate and clear
  task automatic model_map_done();
    int r, c, k, dr, dc, wet, p;
    int unsigned s;
    for (k = 0; k < GRID_SIZE; k++) begin
      rain_map[k * GRID_SIZE] = '0;
      rain_map[k * GRID_SIZE + GRID_SIZE - 1] = '0;
      rain_map[k] = '0;
      rain_map[(GRID_SIZE - 1) * GRID_SIZE + k] = '0;
    end
    for (p = 0; p < map_passes_cfg; p++) begin
      for (c = 1; c < GRID_SIZE - 1; c++) begin
        for (r = 1; r < GRID_SIZE - 1; r++) begin
          if (rain_map[r * GRID_SIZE + c] != 0) begin
            wet = 0;
            for (dc = 0; dc < 3; dc++)
              for (dr = 0; dr < 3; dr++)
                if (int'(rain_map[(r + dr - 1) * GRID_SIZE + c + dc - 1]) > thr_cfg) wet++;
            if (wet < nmin_cfg) rain_map[r * GRID_SIZE + c] = '0;
          end
        end
      end
    end
    for (k = 0; k < CELLS; k++) begin
      s = int'(hour_sums[k]) + int'(rain_map[k]);
      hour_sums[k] = (s > int'(SUM_MAX)) ? SUM_MAX : s[23:0];
      rain_map[k] = '0;
    end
  endtask

  // hour complete: border, row-order passes against twelve times the threshold
  task automatic model_hour_done();
    int r, c, k, dr, dc, wet, p;
    int unsigned lim;
    lim = thr_cfg * 12;
    for (k = 0; k < GRID_SIZE; k++) begin
      hour_sums[k * GRID_SIZE] = '0;
      hour_sums[k * GRID_SIZE + GRID_SIZE - 1] = '0;
      hour_sums[k] = '0;
      hour_sums[(GRID_SIZE - 1) * GRID_SIZE + k] = '0;
    end
    for (p = 0; p < hour_passes_cfg; p++) begin
      for (r = 1; r < GRID_SIZE - 1; r++) begin
        for (c = 1; c < GRID_SIZE - 1; c++) begin
          if (hour_sums[r * GRID_SIZE + c] != 0) begin
            wet = 0;
            for (dr = 0; dr < 3; dr++)
              for (dc = 0; dc < 3; dc++)
                if (int'(hour_sums[(r + dr - 1) * GRID_SIZE + c + dc - 1]) > lim) wet++;
            if (wet < nmin_cfg) hour_sums[r * GRID_SIZE + c] = '0;
          end
        end
      end
    end
  endtask

  // expected effect of one accepted request
  task automatic apply_request(input logic [2:0] rq, input logic [8:0] r, input logic [8:0] c,
                               input logic [15:0] v);
    bit in_grid;
    int idx, k;
    int unsigned q;
    in_grid = (r < GRID_SIZE) && (c < GRID_SIZE);
    idx = in_grid ? int'(r) * GRID_SIZE + int'(c) : 0;
    case (rq)
      REQ_WRITE: if (in_grid) rain_map[idx] = v;
      REQ_MAP_DONE: begin
        model_map_done();
        n_map_done++;
      end
      REQ_HOUR_DONE: begin
        model_hour_done();
        n_hour_done++;
      end
      REQ_READ: begin
        q = in_grid ? int'(hour_sums[idx]) / 12 : 0;
        totals_due.push_back(q[20:0]);
      end
      REQ_CLEAR: for (k = 0; k < CELLS; k++) hour_sums[k] = '0;
      default: ;
    endcase
  endtask

  // send one transaction; entered and left at a falling edge
  task automatic send(input logic [2:0] rq, input logic [8:0] r, input logic [8:0] c,
                      input logic [15:0] v);
    if (pace_on && burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    if (burst_left > 0) burst_left--;
    start = 1'b1;
    req_type = rq;
    row = r;
    col = c;
    pixel_value = v;
    while (busy) @(negedge clk);
    @(posedge clk);
    apply_request(rq, r, c, v);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic put_pixel(input int r, input int c, input logic [15:0] v);
    send(REQ_WRITE, r[8:0], c[8:0], v);
  endtask

  task automatic ask_total(input int r, input int c);
    send(REQ_READ, r[8:0], c[8:0], 16'($urandom()));
  endtask

  // quiet block: nothing pending and the pipeline drained
  task automatic wait_idle();
    start = 1'b0;
    while (busy || totals_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input logic [3:0] idx, input logic [15:0] d);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_THRESHOLD:   thr_cfg = 32'(d);
      CFG_NEIGHBOR:    nmin_cfg = 32'(d[3:0]);
      CFG_MAP_PASSES:  map_passes_cfg = 32'(d[4:0]);
      CFG_HOUR_PASSES: hour_passes_cfg = 32'(d[4:0]);
      default: ;
    endcase
  endtask

  // upper bits of narrow registers are don't-care
  task automatic set_all(input int thr, input int nmin, input int mp, input int hp);
    set_reg(CFG_THRESHOLD, thr[15:0]);
    set_reg(CFG_NEIGHBOR, {12'($urandom_range(0, 4095)), nmin[3:0]});
    set_reg(CFG_MAP_PASSES, {11'($urandom_range(0, 2047)), mp[4:0]});
    set_reg(CFG_HOUR_PASSES, {11'($urandom_range(0, 2047)), hp[4:0]});
  endtask

  task automatic blob(input int r0, input int c0, input logic [15:0] v);
    int dr, dc;
    for (dr = 0; dr < 3; dr++)
      for (dc = 0; dc < 3; dc++)
        put_pixel(r0 + dr, c0 + dc, v);
  endtask

  // grid extremes, out-of-grid addresses, spare codes, a cluster and a speckle
  task automatic test_edges();
    wait_idle();
    set_reg(CFG_SPARE, 16'hFFFF);
    set_reg(CFG_SPARE_TOP, 16'h0000);
    set_all(25, 5, 1, 15);
    put_pixel(0, 0, 16'hFFFF);
    put_pixel(GRID_SIZE - 1, GRID_SIZE - 1, 16'hFFFF);
    put_pixel(0, GRID_SIZE - 1, 16'h1234);
    put_pixel(GRID_SIZE, 3, 16'hFFFF);
    put_pixel(511, 511, 16'hFFFF);
    blob(10, 10, 16'd1000);
    put_pixel(20, 20, 16'hFFFF);
    put_pixel(30, 30, 16'd10);
    send(REQ_SPARE_LO, 9'd11, 9'd11, 16'hFFFF);
    send(REQ_SPARE_MID, 9'd0, 9'd0, 16'h0);
    send(REQ_SPARE_HI, 9'd511, 9'd511, 16'hFFFF);
    send(REQ_MAP_DONE, 9'd0, 9'd0, 16'd0);
    ask_total(11, 11);
    ask_total(10, 10);
    ask_total(10, 11);
    ask_total(20, 20);
    ask_total(0, 0);
    ask_total(GRID_SIZE - 1, GRID_SIZE - 1);
    ask_total(511, 0);
    ask_total(0, 511);
    wait_idle();
  endtask

  // neighbor_min of zero keeps all, above nine removes all; zero passes
  task automatic test_neighbor_and_passes();
    set_all(0, 0, 1, 0);
    put_pixel(50, 50, 16'd7);
    blob(60, 60, 16'd300);
    send(REQ_MAP_DONE, 9'd0, 9'd0, 16'd0);
    ask_total(50, 50);
    ask_total(60, 60);
    wait_idle();
    set_all(65535, 15, 1, 0);
    blob(60, 60, 16'hFFFF);
    put_pixel(70, 70, 16'd1);
    send(REQ_MAP_DONE, 9'd0, 9'd0, 16'd0);
    ask_total(61, 61);
    ask_total(70, 70);
    wait_idle();
    set_all(25, 9, 0, 0);
    put_pixel(80, 80, 16'd5);
    put_pixel(0, 80, 16'd500);
    send(REQ_MAP_DONE, 9'd0, 9'd0, 16'd0);
    ask_total(80, 80);
    ask_total(0, 80);
    wait_idle();
  endtask

  // hour complete with and without passes, then clear total
  task automatic test_hour();
    set_all(25, 5, 0, 1);
    send(REQ_HOUR_DONE, 9'd0, 9'd0, 16'd0);
    ask_total(11, 11);
    ask_total(50, 50);
    ask_total(60, 60);
    wait_idle();
    set_all(25, 1, 0, 0);
    send(REQ_HOUR_DONE, 9'd0, 9'd0, 16'd0);
    ask_total(61, 61);
    send(REQ_CLEAR, 9'd0, 9'd0, 16'd0);
    ask_total(61, 61);
    ask_total(80, 80);
    wait_idle();
    // pass counts at their top, never run to keep the run short
    set_all(65535, 15, 31, 31);
    wait_idle();
  endtask

  // random content: mostly blobs, pixels and reads in a small corner, some noise
  task automatic random_round(input int n_items, input int span);
    int i, pick, r, c;
    logic [15:0] v;
    i = 0;
    while (i < n_items) begin
      pick = $urandom_range(0, 99);
      r = $urandom_range(0, span);
      c = $urandom_range(0, span);
      case ($urandom_range(0, 3))
        0: v = 16'd0;
        1: v = 16'($urandom_range(0, thr_cfg > 65535 ? 65535 : thr_cfg));
        2: v = 16'hFFFF;
        default: v = 16'($urandom());
      endcase
      if (pick < 10) begin
        blob(r, c, v);
        i += 9;
      end else if (pick < 50) begin
        put_pixel(r, c, v);
        i++;
      end else if (pick < 55) begin
        put_pixel($urandom_range(0, 511), $urandom_range(0, 511), 16'($urandom()));
        i++;
      end else if (pick < 90) begin
        ask_total(r, c);
        i++;
      end else if (pick < 95) begin
        ask_total($urandom_range(0, 511), $urandom_range(0, 511));
        i++;
      end else begin
        send(3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)), 9'($urandom()), 9'($urandom()),
             16'($urandom()));
      end
    end
  endtask

  task automatic test_random();
    int k;
    pace_on = 1'b1;
    set_all($urandom_range(0, 2000), $urandom_range(1, 9), 2, 1);
    random_round(400, 24);
    send(REQ_MAP_DONE, 9'd0, 9'd0, 16'd0);
    for (k = 0; k < 40; k++) ask_total($urandom_range(0, 24), $urandom_range(0, 24));
    wait_idle();
    set_all($urandom_range(0, 65535), $urandom_range(0, 15), 1, 1);
    random_round(400, 24);
    send(REQ_MAP_DONE, 9'd0, 9'd0, 16'd0);
    send(REQ_HOUR_DONE, 9'd0, 9'd0, 16'd0);
    for (k = 0; k < 40; k++) ask_total($urandom_range(0, 24), $urandom_range(0, 24));
    wait_idle();
    // back-to-back stretch with no gaps
    pace_on = 1'b0;
    random_round(300, 24);
    pace_on = 1'b1;
    send(REQ_CLEAR, 9'd0, 9'd0, 16'd0);
    random_round(450, 24);
    wait_idle();
  endtask

  initial begin
    int k;
    errors = 0;
    n_sent = 0;
    n_reads_checked = 0;
    n_map_done = 0;
    n_hour_done = 0;
    burst_left = 0;
    pace_on = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    start = 1'b0;
    req_type = REQ_WRITE;
    row = '0;
    col = '0;
    pixel_value = '0;
    for (k = 0; k < CELLS; k++) begin
      rain_map[k] = '0;
      hour_sums[k] = '0;
    end
    thr_cfg = 25;
    nmin_cfg = 5;
    map_passes_cfg = 16;
    hour_passes_cfg = 15;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_edges();
    test_neighbor_and_passes();
    test_hour();
    test_random();

    wait_idle();
    $display("sent %0d requests, checked %0d read totals", n_sent, n_reads_checked);
    $display("ran %0d map completes and %0d hour completes", n_map_done, n_hour_done);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
